>>> src/lj_pkg.sv
// Shared types, constants and register codes for the Lennard-Jones grid energy block.
`default_nettype none

package lj_pkg;

    localparam int MAX_ATOMS_DEF   = 256;
    localparam int GRID_EXTENT_DEF = 1024;
    localparam int DIMENSIONS_DEF  = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ENERGY_W   = 48;
    localparam int IN_DATA_W  = 200;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ATOM_CNT  = 3'd6;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [31:0] SPACING_RESET = 32'h0001_0000;

    typedef struct packed {
        logic        is_eval;
        logic [7:0]  slot;
        logic [31:0] atom_x;
        logic [31:0] atom_y;
        logic [31:0] atom_z;
        logic [31:0] well_depth;
        logic [31:0] contact_size;
        logic [9:0]  point_i;
        logic [9:0]  point_j;
        logic [9:0]  point_k;
    } t_cmd;

    typedef struct packed {
        logic [31:0] spacing_x;
        logic [31:0] spacing_y;
        logic [31:0] spacing_z;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
        logic [8:0]  atom_count;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

>>> src/lennard_jones_grid_energy.sv
// Top level of the Lennard-Jones 12-6 grid energy engine with its register file.
//
// This block sums the Lennard-Jones 12-6 energy 4*eps*((s/r)^12 - (s/r)^6) at one grid
// point over the first atom_count entries of an on-chip atom table. A word with tuser 0
// loads one atom entry and produces no result; a word with tuser 1 evaluates the grid point
// origin + index * spacing and produces one result word carrying the signed Q24.24 energy
// and, in tuser, a flag that is set when any term or the running sum was clipped. A load
// is written into the table only while the evaluation engine is idle. An evaluate runs
// setup, then one pass per summed atom, then output: the engine walks the table one atom
// at a time through one shared 32x32 multiplier and a one-bit-per-cycle divider, so the 64
// divide steps and the sixteen partial products of the four 64-bit products set the per-atom
// time. A two-word command queue sits between the input stage and the engine, so new words
// are taken while an evaluation runs, and the result sits in an output register so the engine
// can start the next word while it waits. Configuration registers may only be written while
// no evaluation is in flight. Reading a table entry that was never loaded gives an undefined
// energy.
`default_nettype none

module lennard_jones_grid_energy #(
    parameter int MAX_ATOMS   = lj_pkg::MAX_ATOMS_DEF,
    parameter int GRID_EXTENT = lj_pkg::GRID_EXTENT_DEF,
    parameter int DIMENSIONS  = lj_pkg::DIMENSIONS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Input word. tdata from bit 0: atom_slot[8], atom_x[32], atom_y[32], atom_z[32],
    // well_depth[32], contact_size[32], point_i[10], point_j[10], point_k[10], zero pad[2].
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire [lj_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: func (0 load an atom, 1 evaluate a point).
    input  wire                          i_s_axis_tuser,
    // Result word. tdata: energy[48], signed Q24.24.
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    output logic [lj_pkg::ENERGY_W-1:0]  o_m_axis_tdata,
    // tuser: saturated.
    output logic                         o_m_axis_tuser,
    // Register write port.
    input  wire                          i_cfg_we,
    input  wire [lj_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [lj_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lj_pkg::t_cfg   r_cfg;
    lj_pkg::t_cmd   w_front_cmd;
    lj_pkg::t_cmd   w_queue_cmd;
    lj_pkg::t_qstat w_qstat;
    logic           w_push;
    logic           w_pop;

    // Register file. Writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing_x  <= lj_pkg::SPACING_RESET;
            r_cfg.spacing_y  <= lj_pkg::SPACING_RESET;
            r_cfg.spacing_z  <= lj_pkg::SPACING_RESET;
            r_cfg.origin_x   <= '0;
            r_cfg.origin_y   <= '0;
            r_cfg.origin_z   <= '0;
            r_cfg.atom_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lj_pkg::REG_SPACING_X: r_cfg.spacing_x  <= i_cfg_data;
                lj_pkg::REG_SPACING_Y: r_cfg.spacing_y  <= i_cfg_data;
                lj_pkg::REG_SPACING_Z: r_cfg.spacing_z  <= i_cfg_data;
                lj_pkg::REG_ORIGIN_X:  r_cfg.origin_x   <= i_cfg_data;
                lj_pkg::REG_ORIGIN_Y:  r_cfg.origin_y   <= i_cfg_data;
                lj_pkg::REG_ORIGIN_Z:  r_cfg.origin_z   <= i_cfg_data;
                lj_pkg::REG_ATOM_CNT:  r_cfg.atom_count <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    lj_front #(
        .MAX_ATOMS   (MAX_ATOMS),
        .GRID_EXTENT (GRID_EXTENT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    lj_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_qstat (w_qstat)
    );

    lj_back #(
        .MAX_ATOMS  (MAX_ATOMS),
        .DIMENSIONS (DIMENSIONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!w_qstat.empty),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_energy    (o_m_axis_tdata),
        .o_saturated (o_m_axis_tuser)
    );

    // The input stage must never push into a full queue, or a word is lost.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("command pushed into full queue");

    // The engine must only take a command that is really there.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("command popped from empty queue");

    // No result is offered straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

>>> src/lj_front.sv
// Input stage: unpacks a word, clamps grid indexes, drops loads beyond the table.
`default_nettype none

module lj_front #(
    parameter int MAX_ATOMS   = lj_pkg::MAX_ATOMS_DEF,
    parameter int GRID_EXTENT = lj_pkg::GRID_EXTENT_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_tvalid,
    output logic                        o_tready,
    input  wire [lj_pkg::IN_DATA_W-1:0] i_tdata,
    input  wire                         i_tuser,
    input  lj_pkg::t_qstat              i_qstat,
    output logic                        o_push,
    output lj_pkg::t_cmd                o_cmd
);

    logic         r_valid;
    lj_pkg::t_cmd r_cmd;
    lj_pkg::t_cmd w_cmd;
    logic         w_keep;
    logic         w_accept;

    function automatic logic [9:0] clamp_idx(input logic [9:0] idx);
        logic [9:0] res;
        res = idx;
        if (32'(idx) > GRID_EXTENT - 1) begin
            res = 10'(GRID_EXTENT - 1);
        end
        return res;
    endfunction

    always_comb begin
        w_cmd.is_eval      = (i_tuser == lj_pkg::FUNC_EVAL);
        w_cmd.slot         = i_tdata[7:0];
        w_cmd.atom_x       = i_tdata[39:8];
        w_cmd.atom_y       = i_tdata[71:40];
        w_cmd.atom_z       = i_tdata[103:72];
        w_cmd.well_depth   = i_tdata[135:104];
        w_cmd.contact_size = i_tdata[167:136];
        w_cmd.point_i      = clamp_idx(i_tdata[177:168]);
        w_cmd.point_j      = clamp_idx(i_tdata[187:178]);
        w_cmd.point_k      = clamp_idx(i_tdata[197:188]);
        w_keep             = w_cmd.is_eval || (32'(w_cmd.slot) < MAX_ATOMS);
    end

    assign o_tready = !r_valid || !i_qstat.full;
    assign w_accept = i_tvalid && o_tready;
    assign o_push   = r_valid && !i_qstat.full;
    assign o_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_push) begin
                r_valid <= 1'b0;
            end
            if (w_accept) begin
                r_valid <= w_keep;
            end
        end
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

`default_nettype wire

>>> src/lj_queue.sv
// Short command queue between the input stage and the evaluation engine.
`default_nettype none

module lj_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  lj_pkg::t_cmd    i_cmd,
    input  wire             i_pop,
    output lj_pkg::t_cmd    o_cmd,
    output lj_pkg::t_qstat  o_qstat
);

    localparam int DEPTH = lj_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lj_pkg::t_cmd   r_mem [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign w_push        = i_push && !o_qstat.full;
    assign w_pop         = i_pop && !o_qstat.empty;
    assign o_cmd         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wptr + 1'b1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rptr + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (w_pop && !w_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> src/lj_back.sv
// Evaluation engine: atom table, per-atom sequencer, shared multiplier and divider.
`default_nettype none

module lj_back #(
    parameter int MAX_ATOMS  = lj_pkg::MAX_ATOMS_DEF,
    parameter int DIMENSIONS = lj_pkg::DIMENSIONS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  lj_pkg::t_cfg                 i_cfg,
    input  wire                          i_cmd_valid,
    input  lj_pkg::t_cmd                 i_cmd,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  wire                          i_tready,
    output logic [lj_pkg::ENERGY_W-1:0]  o_energy,
    output logic                         o_saturated
);

    localparam int AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int NW  = $clog2(MAX_ATOMS + 1);
    localparam int SW  = (AW > 8) ? AW : 8;
    localparam int CW  = 45;
    localparam int EW  = lj_pkg::ENERGY_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DMUL, S_DADD, S_ARD, S_RMUL, S_RADD, S_SMUL, S_SADD,
        S_DIV, S_MMUL, S_MADD, S_MFIN, S_OUT
    } t_state;

    typedef enum logic [1:0] { M_Q2, M_Q3, M_Q6, M_EPS } t_mstep;

    t_state                r_state;
    t_mstep                r_step;
    logic [159:0]          r_mem [MAX_ATOMS];
    logic [159:0]          r_rd;
    logic signed [CW-1:0]  r_coord [3];
    logic [1:0]            r_ax;
    logic                  r_clip;
    logic [63:0]           r_diag2;
    logic [63:0]           r_r2;
    logic [63:0]           r_pp;
    logic [NW-1:0]         r_atom;
    logic [NW-1:0]         r_n;
    logic [63:0]           r_rem;
    logic [63:0]           r_low;
    logic [63:0]           r_q;
    logic [5:0]            r_bit;
    logic [63:0]           r_ma;
    logic [63:0]           r_mb;
    logic [1:0]            r_pc;
    logic [127:0]          r_prod;
    logic [63:0]           r_q3;
    logic                  r_neg;
    logic signed [EW-1:0]  r_acc;
    logic                  r_ovalid;
    logic [EW-1:0]         r_oenergy;
    logic                  r_osat;

    logic [31:0]           w_ma;
    logic [31:0]           w_mb;
    logic [63:0]           w_mp;
    logic [31:0]           w_spacing;
    logic [31:0]           w_pos;
    logic signed [CW:0]    w_df;
    logic [CW:0]           w_abs;
    logic                  w_adclip;
    logic [31:0]           w_ad;
    logic [SW-1:0]         w_slot;
    logic                  w_we;
    logic [AW-1:0]         w_raddr;
    logic                  w_last_ax;
    logic                  w_ge;
    logic [63:0]           w_t;
    logic                  w_qsat;
    logic [63:0]           w_qv;
    logic                  w_mclip;
    logic [46:0]           w_mag;
    logic signed [EW:0]    w_sum;
    logic [NW-1:0]         w_n;
    logic [NW-1:0]         w_atom_nx;
    logic [64:0]           w_dsum;
    logic [64:0]           w_rsum;

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64] ? {1'b1, 64'hFFFF_FFFF_FFFF_FFFF} : s;
    endfunction

    function automatic logic signed [CW-1:0] coord(input logic [31:0] org,
                                                   input logic [31:0] spc,
                                                   input logic [9:0] idx);
        logic [41:0] prod;
        prod = 42'(idx) * 42'(spc);
        return $signed({{13{org[31]}}, org}) + $signed({3'b000, prod});
    endfunction

    always_comb begin
        case (r_ax)
            2'd0:    w_spacing = i_cfg.spacing_x;
            2'd1:    w_spacing = i_cfg.spacing_y;
            default: w_spacing = i_cfg.spacing_z;
        endcase
        case (r_ax)
            2'd0:    w_pos = r_rd[31:0];
            2'd1:    w_pos = r_rd[63:32];
            default: w_pos = r_rd[95:64];
        endcase
        w_df     = $signed({r_coord[r_ax][CW-1], r_coord[r_ax]})
                 - $signed({{(CW - 31){w_pos[31]}}, w_pos});
        w_abs    = w_df[CW] ? (CW+1)'(-w_df) : w_df;
        w_adclip = |w_abs[CW:32];
        w_ad     = w_adclip ? 32'hFFFF_FFFF : w_abs[31:0];

        case (r_state)
            S_DMUL: begin
                w_ma = w_spacing;
                w_mb = w_spacing;
            end
            S_RMUL: begin
                w_ma = w_ad;
                w_mb = w_ad;
            end
            S_SMUL: begin
                w_ma = r_rd[159:128];
                w_mb = r_rd[159:128];
            end
            S_MMUL: begin
                w_ma = r_pc[1] ? r_ma[63:32] : r_ma[31:0];
                w_mb = r_pc[0] ? r_mb[63:32] : r_mb[31:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_mp = {32'b0, w_ma} * {32'b0, w_mb};
    end

    always_comb begin
        w_slot    = SW'(i_cmd.slot);
        w_we      = (r_state == S_IDLE) && i_cmd_valid && !i_cmd.is_eval;
        w_raddr   = r_atom[AW-1:0];
        w_last_ax = (r_ax == 2'(DIMENSIONS - 1));
        w_n       = (32'(i_cfg.atom_count) > MAX_ATOMS) ? NW'(MAX_ATOMS)
                                                        : NW'(i_cfg.atom_count);
        w_atom_nx = NW'(r_atom + 1'b1);
        w_dsum    = sat_add(r_diag2, r_pp);
        w_rsum    = sat_add(r_r2, r_pp);

        w_t  = {r_rem[62:0], r_low[63]};
        w_ge = r_rem[63] || (w_t >= r_r2);

        w_qsat = |r_prod[127:96];
        w_qv   = w_qsat ? 64'hFFFF_FFFF_FFFF_FFFF : r_prod[95:32];

        w_mclip = |r_prod[127:69];
        w_mag   = w_mclip ? 47'h7FFF_FFFF_FFFF : r_prod[68:22];
        w_sum   = r_neg ? $signed({r_acc[EW-1], r_acc}) - $signed({2'b00, w_mag})
                        : $signed({r_acc[EW-1], r_acc}) + $signed({2'b00, w_mag});
    end

    assign o_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_tvalid    = r_ovalid;
    assign o_energy    = r_oenergy;
    assign o_saturated = r_osat;

    // Atom table: one write port for loads, one registered read for the sweep.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_slot[AW-1:0]] <= {i_cmd.contact_size, i_cmd.well_depth,
                                      i_cmd.atom_z, i_cmd.atom_y, i_cmd.atom_x};
        end
        if (r_state == S_ARD) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp <= w_mp;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.is_eval) begin
                        r_coord[0] <= coord(i_cfg.origin_x, i_cfg.spacing_x, i_cmd.point_i);
                        r_coord[1] <= coord(i_cfg.origin_y, i_cfg.spacing_y, i_cmd.point_j);
                        r_coord[2] <= coord(i_cfg.origin_z, i_cfg.spacing_z, i_cmd.point_k);
                        r_ax    <= '0;
                        r_diag2 <= '0;
                        r_clip  <= 1'b0;
                        r_acc   <= '0;
                        r_atom  <= '0;
                        r_n     <= w_n;
                        r_state <= S_DMUL;
                    end
                end
                S_DMUL: r_state <= S_DADD;
                S_DADD: begin
                    r_diag2 <= w_dsum[63:0];
                    if (w_dsum[64]) begin
                        r_clip <= 1'b1;
                    end
                    if (w_last_ax) begin
                        r_ax    <= '0;
                        r_state <= (r_n == '0) ? S_OUT : S_ARD;
                    end else begin
                        r_ax    <= 2'(r_ax + 1'b1);
                        r_state <= S_DMUL;
                    end
                end
                S_ARD: begin
                    r_r2    <= '0;
                    r_state <= S_RMUL;
                end
                S_RMUL: begin
                    if (w_adclip) begin
                        r_clip <= 1'b1;
                    end
                    r_state <= S_RADD;
                end
                S_RADD: begin
                    r_r2 <= w_rsum[63:0];
                    if (w_rsum[64]) begin
                        r_clip <= 1'b1;
                    end
                    if (w_last_ax) begin
                        r_ax    <= '0;
                        r_state <= S_SMUL;
                    end else begin
                        r_ax    <= 2'(r_ax + 1'b1);
                        r_state <= S_RMUL;
                    end
                end
                S_SMUL: begin
                    // Distance floor: cell diagonal, and never below one LSB.
                    if (r_r2 < r_diag2) begin
                        r_r2 <= (r_diag2 == '0) ? 64'd1 : r_diag2;
                    end else if (r_r2 == '0) begin
                        r_r2 <= 64'd1;
                    end
                    r_state <= S_SADD;
                end
                S_SADD: begin
                    r_step <= M_Q2;
                    r_pc   <= '0;
                    r_prod <= '0;
                    if ({32'b0, r_pp[63:32]} >= r_r2) begin
                        r_clip  <= 1'b1;
                        r_q     <= 64'hFFFF_FFFF_FFFF_FFFF;
                        r_ma    <= 64'hFFFF_FFFF_FFFF_FFFF;
                        r_mb    <= 64'hFFFF_FFFF_FFFF_FFFF;
                        r_state <= S_MMUL;
                    end else begin
                        r_rem   <= {32'b0, r_pp[63:32]};
                        r_low   <= {r_pp[31:0], 32'b0};
                        r_q     <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_t - r_r2 : w_t;
                    r_low <= {r_low[62:0], 1'b0};
                    r_q   <= {r_q[62:0], w_ge};
                    r_bit <= 6'(r_bit + 1'b1);
                    if (r_bit == 6'h3F) begin
                        r_ma    <= {r_q[62:0], w_ge};
                        r_mb    <= {r_q[62:0], w_ge};
                        r_state <= S_MMUL;
                    end
                end
                S_MMUL: r_state <= S_MADD;
                S_MADD: begin
                    case (r_pc)
                        2'd0:    r_prod <= r_prod + 128'(r_pp);
                        2'd3:    r_prod <= r_prod + {r_pp, 64'b0};
                        default: r_prod <= r_prod + {32'b0, r_pp, 32'b0};
                    endcase
                    r_pc    <= 2'(r_pc + 1'b1);
                    r_state <= (r_pc == 2'd3) ? S_MFIN : S_MMUL;
                end
                S_MFIN: begin
                    r_pc   <= '0;
                    r_prod <= '0;
                    case (r_step)
                        M_Q2: begin
                            if (w_qsat) r_clip <= 1'b1;
                            r_ma    <= w_qv;
                            r_mb    <= r_q;
                            r_step  <= M_Q3;
                            r_state <= S_MMUL;
                        end
                        M_Q3: begin
                            if (w_qsat) r_clip <= 1'b1;
                            r_q3    <= w_qv;
                            r_ma    <= w_qv;
                            r_mb    <= w_qv;
                            r_step  <= M_Q6;
                            r_state <= S_MMUL;
                        end
                        M_Q6: begin
                            if (w_qsat) r_clip <= 1'b1;
                            r_neg   <= (w_qv < r_q3);
                            r_ma    <= {32'b0, r_rd[127:96]};
                            r_mb    <= (w_qv < r_q3) ? r_q3 - w_qv : w_qv - r_q3;
                            r_step  <= M_EPS;
                            r_state <= S_MMUL;
                        end
                        default: begin
                            if (w_mclip) r_clip <= 1'b1;
                            if (!w_sum[EW] && w_sum[EW-1]) begin
                                r_acc  <= {1'b0, {(EW-1){1'b1}}};
                                r_clip <= 1'b1;
                            end else if (w_sum[EW] && !w_sum[EW-1]) begin
                                r_acc  <= {1'b1, {(EW-1){1'b0}}};
                                r_clip <= 1'b1;
                            end else begin
                                r_acc <= w_sum[EW-1:0];
                            end
                            r_atom  <= w_atom_nx;
                            r_state <= (w_atom_nx == r_n) ? S_OUT : S_ARD;
                        end
                    endcase
                end
                S_OUT: begin
                    if (!r_ovalid || i_tready) begin
                        r_ovalid  <= 1'b1;
                        r_oenergy <= r_acc;
                        r_osat    <= r_clip;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
